>>> hdl/abna_pkg.sv
// Shared types, constants and helpers of the alpha bleed neighbour average block.
package abna_pkg;

   // Largest frame width the line stores are built for
   localparam int unsigned MAX_WIDTH_DEFAULT = 2048;

   // Register reset values
   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd256;
   localparam logic [15:0] FRAME_HEIGHT_RESET = 16'd256;

   // Register index, taken from the word address of the configuration port
   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_NEXT,
      ST_READ_DOWN,
      ST_FINISH
   } state_type;

   // One RGBA pixel, red in the low byte
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
      logic       drain;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [15:0] frame_height;
   } cfg_type;

   // Truncating divide of a channel sum by a neighbour count of 1 to 4
   function automatic logic [7:0] avg_div(input logic [9:0] sum, input logic [2:0] count);
      logic [19:0] prod;
      logic [7:0]  quo;
      prod = 20'(sum) * 20'd683;
      case (count)
         3'd2:    quo = sum[8:1];
         3'd3:    quo = prod[18:11];
         3'd4:    quo = sum[9:2];
         default: quo = sum[7:0];
      endcase
      return quo;
   endfunction

endpackage

>>> hdl/alpha_bleed_neighbour_average.sv
// Top level of the alpha bleed neighbour average block: sequencer and line stores.
//
// Pixels of a frame enter on the req_ channel in raster order; finished pixels
// leave on the rsp_ channel in the same order, one line plus one pixel behind.
// A transaction with drain set carries no pixel and pushes one held pixel out.
// frame_end marks the last pixel of each frame. Frame width and height are
// written through the APB-style port (pready is always high).
// A transaction that produces no pixel leaves the sequencer idle; one that
// finishes a pixel starts three reads (oldest, right and down neighbour) in
// ST_IDLE, ST_READ_NEXT and ST_READ_DOWN through the single read port of the
// delay line, and req_stall stays high until ST_FINISH loads the output register.
// A new transaction is accepted while the finished pixel still waits there.
// Reset clears the row/column position, the fill count and the left neighbour;
// the line memories are not cleared. While the receiver stalls and the output
// register is full, the sequencer holds its finished pixel and req_stall stays
// high until the register frees.
module alpha_bleed_neighbour_average #(
   parameter int unsigned MAX_WIDTH = abna_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  abna_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output abna_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int unsigned DEPTH  = MAX_WIDTH + 1;
   localparam int unsigned AW     = $clog2(DEPTH);
   localparam int unsigned FILL_W = $clog2(DEPTH + 1);
   localparam int unsigned CW     = $clog2(MAX_WIDTH);

   abna_pkg::cfg_type   cfg;
   abna_pkg::state_type state_ff;
   abna_pkg::state_type state_in;

   logic [FILL_W-1:0]   fill_ff;
   logic [FILL_W-1:0]   fill_in;
   logic [AW-1:0]       read_pos_ff;
   logic [AW-1:0]       read_pos_in;
   logic [CW-1:0]       col_ff;
   logic [CW-1:0]       col_in;
   logic [15:0]         row_ff;
   logic [15:0]         row_in;
   abna_pkg::pixel_type left_ff;
   abna_pkg::pixel_type left_in;
   abna_pkg::pixel_type old_ff;
   abna_pkg::pixel_type right_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   abna_pkg::rsp_type   rsp_payload_ff;

   logic [FILL_W-1:0]   w_eff;
   logic [15:0]         h_eff;
   logic                accept;
   logic                room;
   logic                emit;
   logic [FILL_W-1:0]   fill_after;
   logic                done;
   logic [AW:0]         wr_sum;
   logic [AW:0]         down_sum;
   logic [AW-1:0]       wr_addr;
   logic [AW-1:0]       next_addr;
   logic [AW-1:0]       down_addr;
   logic [AW-1:0]       next_read_pos;
   logic                line_wr_en;
   logic                line_rd_en;
   logic [AW-1:0]       line_rd_addr;
   abna_pkg::pixel_type line_rd_data;
   abna_pkg::pixel_type row_rd_data;
   abna_pkg::pixel_type in_pixel;
   abna_pkg::pixel_type result;
   logic                row_end;
   logic                last_row;
   logic                interior;
   logic                right_ok;
   logic                down_ok;

   abna_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Clamp the registers to the supported frame size
   always_comb begin
      if (cfg.frame_width == 12'd0) begin
         w_eff = FILL_W'(1);
      end else if (32'(cfg.frame_width) > 32'(MAX_WIDTH)) begin
         w_eff = FILL_W'(MAX_WIDTH);
      end else begin
         w_eff = FILL_W'(cfg.frame_width);
      end
   end
   assign h_eff = (cfg.frame_height == 16'd0) ? 16'd1 : cfg.frame_height;

   // Input transaction and the decision whether it finishes a pixel
   assign accept     = req_valid && (state_ff == abna_pkg::ST_IDLE);
   assign req_stall  = state_ff != abna_pkg::ST_IDLE;
   assign room       = fill_ff != FILL_W'(DEPTH);
   assign fill_after = (!req_payload.drain && room) ? fill_ff + FILL_W'(1) : fill_ff;
   assign emit       = req_payload.drain ? (fill_ff != FILL_W'(0)) : (fill_after > w_eff);

   assign in_pixel.red   = req_payload.in_red;
   assign in_pixel.green = req_payload.in_green;
   assign in_pixel.blue  = req_payload.in_blue;
   assign in_pixel.alpha = req_payload.in_alpha;

   // Circular addresses into the delay line
   assign wr_sum    = (AW+1)'(read_pos_ff) + (AW+1)'(fill_ff);
   assign wr_addr   = (wr_sum >= (AW+1)'(DEPTH)) ? AW'(wr_sum - (AW+1)'(DEPTH)) : AW'(wr_sum);
   assign down_sum  = (AW+1)'(read_pos_ff) + (AW+1)'(w_eff);
   assign down_addr = (down_sum >= (AW+1)'(DEPTH)) ?
                      AW'(down_sum - (AW+1)'(DEPTH)) : AW'(down_sum);
   assign next_addr = (read_pos_ff == AW'(DEPTH - 1)) ? AW'(0) : read_pos_ff + AW'(1);
   assign next_read_pos = next_addr;

   assign line_wr_en = accept && !req_payload.drain && room;

   // Sequencer: next state and read port control
   always_comb begin
      state_in     = state_ff;
      line_rd_en   = 1'b0;
      line_rd_addr = read_pos_ff;
      case (state_ff)
         abna_pkg::ST_IDLE: begin
            if (accept) begin
               line_rd_en = 1'b1;
               if (emit) begin
                  state_in = abna_pkg::ST_READ_NEXT;
               end
            end
         end
         abna_pkg::ST_READ_NEXT: begin
            line_rd_en   = 1'b1;
            line_rd_addr = next_addr;
            state_in     = abna_pkg::ST_READ_DOWN;
         end
         abna_pkg::ST_READ_DOWN: begin
            line_rd_en   = 1'b1;
            line_rd_addr = down_addr;
            state_in     = abna_pkg::ST_FINISH;
         end
         abna_pkg::ST_FINISH: begin
            if (done) begin
               state_in = abna_pkg::ST_IDLE;
            end
         end
         default: state_in = abna_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abna_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   abna_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (wr_addr),
      .wr_data (in_pixel),
      .rd_en   (line_rd_en),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   // Finished row: read the up neighbour on accept, write back on finish
   abna_ram #(
      .WIDTH (32),
      .DEPTH (MAX_WIDTH)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (done),
      .wr_addr (col_ff),
      .wr_data (result),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (row_rd_data)
   );

   // Capture the oldest and the right neighbour as they come out of the line
   always_ff @(posedge clock) begin
      if (state_ff == abna_pkg::ST_READ_NEXT) begin
         old_ff <= line_rd_data;
      end
      if (state_ff == abna_pkg::ST_READ_DOWN) begin
         right_ff <= line_rd_data;
      end
   end

   // Position of the pixel being finished
   assign row_end  = (FILL_W'(col_ff) + FILL_W'(1)) >= w_eff;
   assign last_row = (17'(row_ff) + 17'd1) >= 17'(h_eff);
   assign interior = (row_ff != 16'd0) && !last_row && (col_ff != CW'(0)) && !row_end;
   assign right_ok = fill_ff >= FILL_W'(2);
   assign down_ok  = fill_ff > w_eff;

   abna_average u_average (
      .center   (old_ff),
      .up       (row_rd_data),
      .left     (left_ff),
      .right    (right_ff),
      .down     (line_rd_data),
      .right_ok (right_ok),
      .down_ok  (down_ok),
      .interior (interior),
      .result   (result)
   );

   assign done = (state_ff == abna_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Advance fill, read pointer and position
   always_comb begin
      fill_in     = fill_ff;
      read_pos_in = read_pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      if (line_wr_en) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      if (done) begin
         fill_in     = fill_ff - FILL_W'(1);
         read_pos_in = next_read_pos;
         left_in     = result;
         if (row_end) begin
            col_in = CW'(0);
            row_in = last_row ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         read_pos_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
      end else begin
         fill_ff     <= fill_in;
         read_pos_ff <= read_pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         left_ff     <= left_in;
      end
   end

   // Output register: load on finish, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_payload_ff.out_red   <= result.red;
         rsp_payload_ff.out_green <= result.green;
         rsp_payload_ff.out_blue  <= result.blue;
         rsp_payload_ff.out_alpha <= result.alpha;
         rsp_payload_ff.frame_end <= last_row && row_end;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> hdl/abna_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module abna_ram #(
   parameter int unsigned WIDTH  = 32,
   parameter int unsigned DEPTH  = 2048,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and register the read word; the output holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/abna_csr.sv
// APB-style register file holding frame width and frame height.
module abna_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output abna_pkg::cfg_type   cfg
);

   logic [11:0]             frame_width_ff;
   logic [11:0]             frame_width_in;
   logic [15:0]             frame_height_ff;
   logic [15:0]             frame_height_in;
   logic                    wr_strobe;
   abna_pkg::reg_index_type reg_index;

   assign pready    = 1'b1;
   assign reg_index = abna_pkg::reg_index_type'(paddr[2]);
   assign wr_strobe = psel && penable && pwrite && pready;

   // Decode the write transaction
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (wr_strobe) begin
         case (reg_index)
            abna_pkg::REG_FRAME_WIDTH:  frame_width_in  = pwdata[11:0];
            abna_pkg::REG_FRAME_HEIGHT: frame_height_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= abna_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= abna_pkg::FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // Return the addressed register
   always_comb begin
      case (reg_index)
         abna_pkg::REG_FRAME_WIDTH:  prdata = {20'd0, frame_width_ff};
         abna_pkg::REG_FRAME_HEIGHT: prdata = {16'd0, frame_height_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   assign cfg.frame_width  = frame_width_ff;
   assign cfg.frame_height = frame_height_ff;

endmodule

>>> hdl/abna_average.sv
// Four-neighbour average of opaque neighbours for one interior pixel.
module abna_average (
   input  abna_pkg::pixel_type center,
   input  abna_pkg::pixel_type up,
   input  abna_pkg::pixel_type left,
   input  abna_pkg::pixel_type right,
   input  abna_pkg::pixel_type down,
   input  logic                right_ok,
   input  logic                down_ok,
   input  logic                interior,
   output abna_pkg::pixel_type result
);

   logic       use_up;
   logic       use_left;
   logic       use_right;
   logic       use_down;
   logic [2:0] count;
   logic [9:0] sum_red;
   logic [9:0] sum_green;
   logic [9:0] sum_blue;

   // Count only neighbours that exist and are not transparent
   assign use_up    = up.alpha != 8'd0;
   assign use_left  = left.alpha != 8'd0;
   assign use_right = right_ok && (right.alpha != 8'd0);
   assign use_down  = down_ok && (down.alpha != 8'd0);

   assign count = 3'(use_up) + 3'(use_left) + 3'(use_right) + 3'(use_down);

   assign sum_red   = (use_up    ? 10'(up.red)    : 10'd0)
                    + (use_left  ? 10'(left.red)  : 10'd0)
                    + (use_right ? 10'(right.red) : 10'd0)
                    + (use_down  ? 10'(down.red)  : 10'd0);
   assign sum_green = (use_up    ? 10'(up.green)    : 10'd0)
                    + (use_left  ? 10'(left.green)  : 10'd0)
                    + (use_right ? 10'(right.green) : 10'd0)
                    + (use_down  ? 10'(down.green)  : 10'd0);
   assign sum_blue  = (use_up    ? 10'(up.blue)    : 10'd0)
                    + (use_left  ? 10'(left.blue)  : 10'd0)
                    + (use_right ? 10'(right.blue) : 10'd0)
                    + (use_down  ? 10'(down.blue)  : 10'd0);

   // Replace color only on interior pixels with at least one opaque neighbour
   always_comb begin
      result = center;
      if (interior && (count != 3'd0)) begin
         result.red   = abna_pkg::avg_div(sum_red, count);
         result.green = abna_pkg::avg_div(sum_green, count);
         result.blue  = abna_pkg::avg_div(sum_blue, count);
      end
   end

endmodule
